// ===== rtl/evd_pkg.sv =====
// Shared types, constants and a helper function of the edge block varint decoder.
`default_nettype none

package evd_pkg;

   // Key width used by the range check, and the width of the key ports.
   localparam int KEY_BITS     = 48;
   localparam int OUT_KEY_BITS = 48;

   // FNV-1a constants.
   localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

   // Byte queue between the hash front end and the decode back end.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_CHECKSUM = 3'd1,
      STATUS_VARINT   = 3'd2,
      STATUS_RANGE    = 3'd3,
      STATUS_TRAILING = 3'd4
   } status_type;

   typedef enum logic {
      KIND_EDGE   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_RECORD_COUNT      = 1'b0,
      CSR_EXPECTED_CHECKSUM = 1'b1
   } csr_index_type;

   // Position of a varint inside one record.
   typedef enum logic [1:0] {
      FIELD_REP    = 2'd0,
      FIELD_MEMBER = 2'd1,
      FIELD_DIAG   = 2'd2,
      FIELD_SCORE  = 2'd3
   } field_type;

   // One request byte together with the running hash after it.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] block_hash;
   } byte_entry_type;

   // One result item.
   typedef struct packed {
      kind_type                 kind;
      logic [OUT_KEY_BITS-1:0]  rep_key;
      logic [OUT_KEY_BITS-1:0]  member_key;
      logic signed [15:0]       diag;
      logic [15:0]              edge_score;
      logic                     reverse_strand;
      status_type               status;
   } result_type;

   // Zigzag decode of a 64-bit value.
   function automatic logic [63:0] unzigzag(input logic [63:0] value);
      return (value >> 1) ^ {64{value[0]}};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/evd_front.sv =====
// Front end: accepts request bytes and keeps the running FNV-1a hash of the block.
`default_nettype none

module evd_front
   import evd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [7:0]     req_data_byte,
   input  wire logic           req_last_byte,
   output logic                push_valid,
   input  wire logic           push_ready,
   output byte_entry_type      push_entry
);

   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] hash_next;
   logic        accept;

   // One hash round per byte; the hash restarts after the final byte.
   always_comb begin
      hash_next = (hash_ff ^ {24'd0, req_data_byte}) * FNV_PRIME;
      accept    = req_valid && push_ready;
      hash_in   = hash_ff;
      if (accept) begin
         hash_in = req_last_byte ? FNV_BASIS : hash_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

   // The request goes straight into the byte queue with its hash.
   assign req_ready             = push_ready;
   assign push_valid            = req_valid;
   assign push_entry.data_byte  = req_data_byte;
   assign push_entry.last_byte  = req_last_byte;
   assign push_entry.block_hash = hash_next;

endmodule

`default_nettype wire

// ===== rtl/evd_byte_queue.sv =====
// Short queue of hashed bytes between the front end and the decode back end.
`default_nettype none

module evd_byte_queue
   import evd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   output logic                push_ready,
   input  wire byte_entry_type push_entry,
   output logic                pop_valid,
   input  wire logic           pop_ready,
   output byte_entry_type      pop_entry
);

   byte_entry_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_BITS-1:0]   wr_ptr_ff;
   logic [QUEUE_IDX_BITS-1:0]   wr_ptr_in;
   logic [QUEUE_IDX_BITS-1:0]   rd_ptr_ff;
   logic [QUEUE_IDX_BITS-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff;
   logic [QUEUE_CNT_BITS-1:0]   count_in;
   logic                        do_push;
   logic                        do_pop;

   // Pointer and fill count updates.
   always_comb begin
      push_ready = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
      pop_valid  = (count_ff != '0);
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/evd_back.sv =====
// Back end: varint decode, record rebuild, range checks and the two-slot response stage.
`default_nettype none

module evd_back
   import evd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [31:0]    record_count,
   input  wire logic [31:0]    expected_checksum,
   input  wire logic           pop_valid,
   output logic                pop_ready,
   input  wire byte_entry_type pop_entry,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output result_type          rsp_result
);

   // Block decode state.
   logic [63:0] accum_ff;
   logic [63:0] accum_in;
   logic [3:0]  vbytes_ff;
   logic [3:0]  vbytes_in;
   field_type   field_ff;
   field_type   field_in;
   logic [63:0] prev_ff;
   logic [63:0] prev_in;
   logic [63:0] member_ff;
   logic [63:0] member_in;
   logic [15:0] diag_ff;
   logic [15:0] diag_in;
   logic [31:0] done_ff;
   logic [31:0] done_in;
   status_type  error_ff;
   status_type  error_in;
   logic        range_bad_ff;
   logic        range_bad_in;

   // Response slots: slot 0 is shown, slot 1 holds a status behind an edge.
   result_type  slot0_ff;
   result_type  slot1_ff;
   logic        slot0_valid_ff;
   logic        slot1_valid_ff;

   logic        pop;
   logic        edge_fire;
   logic [6:0]  shift_amt;
   logic [63:0] accum_next;
   logic [63:0] rep_sum;
   logic [63:0] member_sum;
   logic [63:0] diag_value;
   status_type  block_status;
   result_type  edge_result;
   result_type  status_result;

   // A byte is taken only when both its possible results fit.
   assign pop = pop_valid && !slot1_valid_ff && (!slot0_valid_ff || rsp_ready);
   assign pop_ready = pop;

   // Varint accumulation and the per-field arithmetic.
   always_comb begin
      shift_amt  = 7'({3'b000, vbytes_ff} * 7'd7);
      accum_next = accum_ff | ({57'd0, pop_entry.data_byte[6:0]} << shift_amt);
      rep_sum    = prev_ff + accum_next;
      member_sum = prev_ff + unzigzag(accum_next);
      diag_value = unzigzag(accum_next);
   end

   // Next block state for the byte at the head of the queue.
   always_comb begin
      accum_in     = accum_ff;
      vbytes_in    = vbytes_ff;
      field_in     = field_ff;
      prev_in      = prev_ff;
      member_in    = member_ff;
      diag_in      = diag_ff;
      done_in      = done_ff;
      error_in     = error_ff;
      range_bad_in = range_bad_ff;
      edge_fire    = 1'b0;

      if (error_ff == STATUS_OK) begin
         priority if (done_ff >= record_count) begin
            error_in = STATUS_TRAILING;
         end else if (vbytes_ff >= 4'd9 && pop_entry.data_byte > 8'd1) begin
            error_in = STATUS_VARINT;
         end else begin
            accum_in  = accum_next;
            vbytes_in = vbytes_ff + 4'd1;
            if (!pop_entry.data_byte[7]) begin
               // The varint ends here.
               accum_in  = '0;
               vbytes_in = '0;
               field_in  = field_type'(2'(field_ff + 2'd1));
               unique case (field_ff)
                  FIELD_REP: begin
                     prev_in = rep_sum;
                     if (rep_sum[63:KEY_BITS] != '0) begin
                        range_bad_in = 1'b1;
                     end
                  end
                  FIELD_MEMBER: begin
                     member_in = member_sum;
                     if (member_sum[63:KEY_BITS] != '0) begin
                        range_bad_in = 1'b1;
                     end
                  end
                  FIELD_DIAG: begin
                     diag_in = diag_value[15:0];
                     if (diag_value[63:15] != {49{diag_value[15]}}) begin
                        range_bad_in = 1'b1;
                     end
                  end
                  FIELD_SCORE: begin
                     if (accum_next[63:17] != '0 || range_bad_ff) begin
                        error_in = STATUS_RANGE;
                     end else begin
                        edge_fire = 1'b1;
                        done_in   = done_ff + 32'd1;
                     end
                     range_bad_in = 1'b0;
                  end
                  default: begin
                     range_bad_in = range_bad_ff;
                  end
               endcase
            end
         end
      end

      // End-of-block status, checksum mismatch first.
      priority if (pop_entry.block_hash != expected_checksum) begin
         block_status = STATUS_CHECKSUM;
      end else if (error_in != STATUS_OK) begin
         block_status = error_in;
      end else if (done_in != record_count) begin
         block_status = STATUS_VARINT;
      end else begin
         block_status = STATUS_OK;
      end

      // The final byte returns the whole block state to its reset values.
      if (pop_entry.last_byte) begin
         accum_in     = '0;
         vbytes_in    = '0;
         field_in     = FIELD_REP;
         prev_in      = '0;
         member_in    = '0;
         diag_in      = '0;
         done_in      = '0;
         error_in     = STATUS_OK;
         range_bad_in = 1'b0;
      end
   end

   // Result items built from the current record and the block status.
   always_comb begin
      edge_result.kind           = KIND_EDGE;
      edge_result.rep_key        = prev_ff[OUT_KEY_BITS-1:0];
      edge_result.member_key     = member_ff[OUT_KEY_BITS-1:0];
      edge_result.diag           = diag_ff;
      edge_result.edge_score     = accum_next[16:1];
      edge_result.reverse_strand = accum_next[0];
      edge_result.status         = STATUS_OK;

      status_result.kind           = KIND_STATUS;
      status_result.rep_key        = '0;
      status_result.member_key     = '0;
      status_result.diag           = '0;
      status_result.edge_score     = '0;
      status_result.reverse_strand = 1'b0;
      status_result.status         = block_status;
   end

   // Block state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         vbytes_ff    <= '0;
         field_ff     <= FIELD_REP;
         prev_ff      <= '0;
         member_ff    <= '0;
         diag_ff      <= '0;
         done_ff      <= '0;
         error_ff     <= STATUS_OK;
         range_bad_ff <= 1'b0;
      end else if (pop) begin
         accum_ff     <= accum_in;
         vbytes_ff    <= vbytes_in;
         field_ff     <= field_in;
         prev_ff      <= prev_in;
         member_ff    <= member_in;
         diag_ff      <= diag_in;
         done_ff      <= done_in;
         error_ff     <= error_in;
         range_bad_ff <= range_bad_in;
      end
   end

   // Response slot valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_valid_ff <= 1'b0;
         slot1_valid_ff <= 1'b0;
      end else if (pop) begin
         slot0_valid_ff <= edge_fire || pop_entry.last_byte;
         slot1_valid_ff <= edge_fire && pop_entry.last_byte;
      end else if (rsp_ready && slot0_valid_ff) begin
         slot0_valid_ff <= slot1_valid_ff;
         slot1_valid_ff <= 1'b0;
      end
   end

   // Response slot payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         slot0_ff <= edge_fire ? edge_result : status_result;
         slot1_ff <= status_result;
      end else if (rsp_ready && slot0_valid_ff) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_valid  = slot0_valid_ff;
   assign rsp_result = slot0_ff;

endmodule

`default_nettype wire

// ===== rtl/edge_block_varint_decoder_core.sv =====
// Top level of the edge block varint decoder: ports, configuration registers, wiring.
//
// Usage: the request channel (req_valid/req_ready) carries the payload of one packed
// edge block, one byte per request, with req_last_byte on the final byte. The response
// channel (rsp_valid/rsp_ready) returns one decoded edge (kind 0) each time a record's
// fourth varint ends and passes its range checks, and one status item (kind 1) after
// the final byte. Downstream drops the block's edges if that status is not ok.
// Throughput is one request per cycle if the queue has room; the byte hash is a single
// 32-bit multiply loop in the front end and the decode back end retires one queued byte
// per cycle if the response slots have room. A final byte that also ends a record gives
// two responses, edge first, and occupies both response slots. A four-entry byte queue
// and a two-slot response stage decouple the sides: while the receiver stalls, requests
// keep being taken until the queue fills. The csr_ port writes record_count (index 0) and
// expected_checksum (index 1) while the block is idle; the user must see to this, the block
// does not enforce it. Reset sets record_count to 1, expected_checksum to 0, restarts the
// hash and clears decode state; block state also returns to reset after each final byte.
`default_nettype none

module edge_block_varint_decoder_core
   import evd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_data_byte,
   input  wire logic                    req_last_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_kind,
   output logic [OUT_KEY_BITS-1:0]      rsp_rep_key,
   output logic [OUT_KEY_BITS-1:0]      rsp_member_key,
   output logic signed [15:0]           rsp_diag,
   output logic [15:0]                  rsp_edge_score,
   output logic                         rsp_reverse_strand,
   output logic [2:0]                   rsp_status,
   input  wire logic                    csr_wen,
   input  wire logic                    csr_index,
   input  wire logic [31:0]             csr_wdata
);

   logic [31:0]    record_count_ff;
   logic [31:0]    expected_checksum_ff;
   logic           push_valid;
   logic           push_ready;
   byte_entry_type push_entry;
   logic           pop_valid;
   logic           pop_ready;
   byte_entry_type pop_entry;
   result_type     rsp_result;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         record_count_ff      <= 32'd1;
         expected_checksum_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_RECORD_COUNT:      record_count_ff      <= csr_wdata;
            CSR_EXPECTED_CHECKSUM: expected_checksum_ff <= csr_wdata;
            default:               record_count_ff      <= record_count_ff;
         endcase
      end
   end

   evd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_entry    (push_entry)
   );

   evd_byte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   evd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .record_count      (record_count_ff),
      .expected_checksum (expected_checksum_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result        (rsp_result)
   );

   // Response fields.
   assign rsp_kind           = rsp_result.kind;
   assign rsp_rep_key        = rsp_result.rep_key;
   assign rsp_member_key     = rsp_result.member_key;
   assign rsp_diag           = rsp_result.diag;
   assign rsp_edge_score     = rsp_result.edge_score;
   assign rsp_reverse_strand = rsp_result.reverse_strand;
   assign rsp_status         = rsp_result.status;

endmodule

`default_nettype wire
